### src/rgb_gain_with_hue_clamp_macros.svh
`ifndef RGB_GAIN_WITH_HUE_CLAMP_MACROS_SVH
`define RGB_GAIN_WITH_HUE_CLAMP_MACROS_SVH

// Checked only outside reset.
`define RGC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define RGC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/rgc_pkg.sv
package rgc_pkg;

  localparam int GainFracBits = 8;
  localparam int GainW        = 16;
  localparam int ColorW       = 8;
  localparam int CountW       = 3;
  localparam int CfgIdxW      = 2;
  localparam int ProdW        = ColorW + GainW;
  localparam int DivW         = ProdW + ColorW;
  localparam int QuotBits     = ColorW;
  localparam int NumColors    = 3;

  localparam logic [ProdW-1:0]  Limit        = ProdW'((2 ** ColorW) - 1) << GainFracBits;
  localparam logic [GainW-1:0]  GainReset    = GainW'(256);
  localparam logic [CountW-1:0] CountReset   = CountW'(4);
  localparam logic [CountW-1:0] CountMinProc = CountW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    RegGain         = 2'd0,
    RegChannelCount = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0] gain;
    logic             bypass;
  } cfg_t;

  typedef struct packed {
    logic [ColorW-1:0] alpha;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic              last;
  } pix_t;

  typedef struct packed {
    logic [NumColors-1:0][ProdW-1:0] prod;
    logic [ColorW-1:0]               alpha;
    logic                            last;
  } prod_t;

  typedef struct packed {
    logic [NumColors-1:0][DivW-1:0]   rem;
    logic [NumColors-1:0][ColorW-1:0] quot;
    logic [ProdW-1:0]                 peak;
    logic                             norm;
    logic [ColorW-1:0]                alpha;
    logic                             last;
  } div_t;

endpackage

### src/rgc_mult.sv
module rgc_mult (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rgc_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  rgc_pkg::pix_t pix_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rgc_pkg::prod_t prod_o
);

  logic           valid_q;
  rgc_pkg::prod_t data_q, data_d;
  logic [rgc_pkg::ColorW-1:0] color [rgc_pkg::NumColors];

  assign color[0] = pix_i.red;
  assign color[1] = pix_i.green;
  assign color[2] = pix_i.blue;

  assign ready_o = !valid_q || ready_i;

  // Pass-through is forced as a unity product: it never exceeds the limit.
  always_comb begin
    data_d.alpha = pix_i.alpha;
    data_d.last  = pix_i.last;
    for (int c = 0; c < rgc_pkg::NumColors; c++) begin
      if (cfg_i.bypass) begin
        data_d.prod[c] = rgc_pkg::ProdW'(color[c]) << rgc_pkg::GainFracBits;
      end else begin
        data_d.prod[c] = rgc_pkg::ProdW'(color[c]) * rgc_pkg::ProdW'(cfg_i.gain);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = data_q;

endmodule

### src/rgc_peak.sv
module rgc_peak (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rgc_pkg::prod_t prod_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rgc_pkg::div_t  div_o
);

  logic                      valid_q;
  rgc_pkg::div_t             data_q, data_d;
  logic [rgc_pkg::ProdW-1:0] max_rg, peak;
  logic                      norm;

  assign ready_o = !valid_q || ready_i;

  assign max_rg = (prod_i.prod[1] > prod_i.prod[0]) ? prod_i.prod[1] : prod_i.prod[0];
  assign peak   = (prod_i.prod[2] > max_rg) ? prod_i.prod[2] : max_rg;
  assign norm   = peak > rgc_pkg::Limit;

  // Dividend is product * 255; plain path result is preloaded into the quotient.
  always_comb begin
    data_d.peak  = peak;
    data_d.norm  = norm;
    data_d.alpha = prod_i.alpha;
    data_d.last  = prod_i.last;
    for (int c = 0; c < rgc_pkg::NumColors; c++) begin
      data_d.rem[c] = (rgc_pkg::DivW'(prod_i.prod[c]) << rgc_pkg::ColorW)
                    - rgc_pkg::DivW'(prod_i.prod[c]);
      if (norm) begin
        data_d.quot[c] = '0;
      end else begin
        data_d.quot[c] = prod_i.prod[c][rgc_pkg::GainFracBits +: rgc_pkg::ColorW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = data_q;

endmodule

### src/rgc_divider.sv
module rgc_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  rgc_pkg::div_t div_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rgc_pkg::div_t div_o
);

  localparam int Stages = rgc_pkg::QuotBits;

  logic          valid_q [Stages];
  rgc_pkg::div_t stage_q [Stages];
  logic [Stages:0] rdy;

  assign rdy[Stages] = ready_i;
  assign ready_o     = rdy[0];

  // One restoring step per stage, quotient MSB first.
  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam int Bit = Stages - 1 - k;

    logic                     vin;
    rgc_pkg::div_t            src, nxt;
    logic [rgc_pkg::DivW-1:0] dshift;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign src = div_i;
    end else begin : g_next
      assign vin = valid_q[k-1];
      assign src = stage_q[k-1];
    end

    assign dshift = rgc_pkg::DivW'(src.peak) << Bit;
    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_comb begin
      nxt = src;
      for (int c = 0; c < rgc_pkg::NumColors; c++) begin
        if (src.norm && (src.rem[c] >= dshift)) begin
          nxt.rem[c]       = src.rem[c] - dshift;
          nxt.quot[c][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vin && rdy[k]) begin
        stage_q[k] <= nxt;
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign div_o   = stage_q[Stages-1];

endmodule

### src/rgb_gain_with_hue_clamp.sv
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata {alpha,blue,green,red}, tlast
// m_axis    out  tvalid/tready           tdata {alpha,blue,green,red}, tlast
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Pipeline: gain multiply, peak/limit stage, then 8 divider
// stages, one quotient bit each. One pixel per clock sustained while m_axis is not stalled.
// Each stage holds its own valid bit; empty stages fill while the output stalls.
// Reset clears all valid bits and loads gain 1.0 and channel count 4.
// Config writes are always taken.
`include "rgb_gain_with_hue_clamp_macros.svh"

module rgb_gain_with_hue_clamp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
  input  logic        s_axis_tlast,  // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic        m_axis_tlast,  // last_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [rgc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rgc_pkg::GainW-1:0]   cfg_data_i
);

  logic [rgc_pkg::GainW-1:0]  gain_q;
  logic [rgc_pkg::CountW-1:0] count_q;
  rgc_pkg::cfg_t              cfg;
  rgc_pkg::pix_t              pix;
  rgc_pkg::prod_t             prod;
  rgc_pkg::div_t              div_in, div_out;
  logic mult_valid, mult_ready, peak_valid, peak_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= rgc_pkg::GainReset;
      count_q <= rgc_pkg::CountReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rgc_pkg::RegGain: begin
          gain_q <= cfg_data_i;
        end
        rgc_pkg::RegChannelCount: begin
          count_q <= cfg_data_i[rgc_pkg::CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.gain   = gain_q;
  assign cfg.bypass = count_q < rgc_pkg::CountMinProc;

  assign pix.red   = s_axis_tdata[7:0];
  assign pix.green = s_axis_tdata[15:8];
  assign pix.blue  = s_axis_tdata[23:16];
  assign pix.alpha = s_axis_tdata[31:24];
  assign pix.last  = s_axis_tlast;

  rgc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pix_i   (pix),
    .valid_o (mult_valid),
    .ready_i (mult_ready),
    .prod_o  (prod)
  );

  rgc_peak u_peak (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .ready_o (mult_ready),
    .prod_i  (prod),
    .valid_o (peak_valid),
    .ready_i (peak_ready),
    .div_o   (div_in)
  );

  rgc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (peak_valid),
    .ready_o (peak_ready),
    .div_i   (div_in),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .div_o   (div_out)
  );

  assign m_axis_tdata = {div_out.alpha, div_out.quot[2], div_out.quot[1], div_out.quot[0]};
  assign m_axis_tlast = div_out.last;

  `RGC_ASSERT(a_ready_chain, m_axis_tready |-> s_axis_tready, "input stalled while output ready")
  `RGC_ASSERT(a_zero_gain,
    m_axis_tvalid && (gain_q == '0) && (count_q >= rgc_pkg::CountMinProc)
      |-> m_axis_tdata[23:0] == '0,
    "zero gain gave nonzero color")
  `RGC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

### dv/rgb_gain_checker.sv
module rgb_gain_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  input  logic                        s_ready_i,
  input  logic [31:0]                 s_data_i,   // red, green, blue, alpha
  input  logic                        s_last_i,
  input  logic                        m_valid_i,
  input  logic                        m_ready_i,
  input  logic [31:0]                 m_data_i,   // red, green, blue, alpha
  input  logic                        m_last_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [rgc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rgc_pkg::GainW-1:0]   cfg_data_i,
  output int                          pending_o,
  output int                          fail_count_o
);

  logic [rgc_pkg::GainW-1:0]  gain_q;
  logic [rgc_pkg::CountW-1:0] count_q;
  rgc_pkg::pix_t              expected_pixels [$];

  function automatic rgc_pkg::pix_t unpack_pixel(logic [31:0] data, logic last);
    rgc_pkg::pix_t px;
    px.red   = data[7:0];
    px.green = data[15:8];
    px.blue  = data[23:16];
    px.alpha = data[31:24];
    px.last  = last;
    return px;
  endfunction

  function automatic rgc_pkg::pix_t gained_pixel(rgc_pkg::pix_t px,
                                                 logic [rgc_pkg::GainW-1:0] gain,
                                                 logic [rgc_pkg::CountW-1:0] count);
    logic [rgc_pkg::ColorW-1:0] color [rgc_pkg::NumColors];
    logic [rgc_pkg::ProdW-1:0]  prod [rgc_pkg::NumColors];
    logic [rgc_pkg::ProdW-1:0]  peak;
    logic [rgc_pkg::DivW-1:0]   scaled;
    rgc_pkg::pix_t              res;
    res = px;
    if (count < rgc_pkg::CountMinProc) begin
      return res;
    end
    color[0] = px.red;
    color[1] = px.green;
    color[2] = px.blue;
    peak = '0;
    for (int i = 0; i < rgc_pkg::NumColors; i++) begin
      prod[i] = rgc_pkg::ProdW'(color[i]) * rgc_pkg::ProdW'(gain);
      if (prod[i] > peak) peak = prod[i];
    end
    for (int i = 0; i < rgc_pkg::NumColors; i++) begin
      if (peak > rgc_pkg::Limit) begin
        // brightest channel lands on full scale, hue kept
        scaled = (rgc_pkg::DivW'(prod[i]) * rgc_pkg::DivW'(255)) / rgc_pkg::DivW'(peak);
      end else begin
        scaled = rgc_pkg::DivW'(prod[i] >> rgc_pkg::GainFracBits);
      end
      color[i] = scaled[rgc_pkg::ColorW-1:0];
    end
    res.red   = color[0];
    res.green = color[1];
    res.blue  = color[2];
    return res;
  endfunction

  function automatic int field_mismatch(string name, logic [rgc_pkg::ColorW-1:0] want,
                                        logic [rgc_pkg::ColorW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgc_pkg::pix_t got;
    rgc_pkg::pix_t want;
    int            errs;
    if (!rst_ni) begin
      gain_q  <= rgc_pkg::GainReset;
      count_q <= rgc_pkg::CountReset;
      expected_pixels.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        case (rgc_pkg::reg_idx_e'(cfg_index_i))
          rgc_pkg::RegGain:         gain_q  <= cfg_data_i;
          rgc_pkg::RegChannelCount: count_q <= cfg_data_i[rgc_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        got = unpack_pixel(m_data_i, m_last_i);
        if (expected_pixels.size() == 0) begin
          $error("output transaction with nothing expected: tdata %h tlast %b",
                 m_data_i, m_last_i);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          errs += field_mismatch("red_out", want.red, got.red);
          errs += field_mismatch("green_out", want.green, got.green);
          errs += field_mismatch("blue_out", want.blue, got.blue);
          errs += field_mismatch("alpha_out", want.alpha, got.alpha);
          errs += field_mismatch("last_out", rgc_pkg::ColorW'(want.last),
                                 rgc_pkg::ColorW'(got.last));
        end
      end
      if (s_valid_i && s_ready_i) begin
        expected_pixels.push_back(
          gained_pixel(unpack_pixel(s_data_i, s_last_i), gain_q, count_q));
      end
      pending_o    <= expected_pixels.size();
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

### dv/tb_top.sv
module tb_top;

  localparam int StallLimit   = 2000;
  localparam int RandomPhases = 12;
  localparam int PhaseItems   = 62;
  localparam int DrainCycles  = 20;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata = '0;
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [31:0]                 m_axis_tdata;
  logic                        m_axis_tlast;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [rgc_pkg::CfgIdxW-1:0] cfg_index = rgc_pkg::RegGain;
  logic [rgc_pkg::GainW-1:0]   cfg_data = '0;

  int pending;
  int fail_count;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;

  always #5 clk = ~clk;

  rgb_gain_with_hue_clamp u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  rgb_gain_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_last_i    (m_axis_tlast),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // output backpressure: modes of random length
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("rgb_gain_with_hue_clamp verification failed");
      $finish;
    end
  end

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_pixel(input logic [rgc_pkg::ColorW-1:0] red,
                            input logic [rgc_pkg::ColorW-1:0] green,
                            input logic [rgc_pkg::ColorW-1:0] blue,
                            input logic [rgc_pkg::ColorW-1:0] alpha,
                            input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {alpha, blue, green, red};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic configure(input logic [rgc_pkg::GainW-1:0] gain,
                           input logic [rgc_pkg::CountW-1:0] count);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= rgc_pkg::RegGain;
    cfg_data  <= gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= rgc_pkg::RegChannelCount;
    cfg_data  <= {13'($urandom_range(0, 8191)), count};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [rgc_pkg::GainW-1:0]  gain;
    logic [rgc_pkg::CountW-1:0] count;
    bit                         dim;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unity gain, four channels; top pixel sits on the limit
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd1, 8'd128, 8'd254, 8'h5a, 1'b0);
    // zero gain
    configure(16'd0, 3'd3);
    send_pixel(8'd255, 8'd17, 8'd200, 8'ha5, 1'b1);
    // gain 3.0: 85 hits the limit exactly, 86 goes over
    configure(16'd768, 3'd4);
    send_pixel(8'd85, 8'd40, 8'd0, 8'h0f, 1'b0);
    send_pixel(8'd86, 8'd40, 8'd1, 8'hf0, 1'b0);
    send_pixel(8'd0, 8'd85, 8'd86, 8'h33, 1'b1);
    // maximum gain, then gain 128.0; channel counts above four
    configure(16'hffff, 3'd7);
    send_pixel(8'd255, 8'd255, 8'd255, 8'hcc, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd1, 8'd0, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 8'd255, 1'b1);
    configure(16'h8000, 3'd5);
    send_pixel(8'd3, 8'd200, 8'd99, 8'h81, 1'b0);
    configure(16'h8000, 3'd6);
    send_pixel(8'd10, 8'd20, 8'd30, 8'h7e, 1'b1);
    // too few channels: colors pass untouched
    configure(16'd1000, 3'd0);
    send_pixel(8'd255, 8'd100, 8'd7, 8'h12, 1'b0);
    configure(16'd1000, 3'd1);
    send_pixel(8'd33, 8'd44, 8'd55, 8'h34, 1'b0);
    configure(16'd1000, 3'd2);
    send_pixel(8'd200, 8'd1, 8'd250, 8'h56, 1'b1);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case ($urandom_range(0, 3))
        0: gain = rgc_pkg::GainW'($urandom_range(0, 511));
        1: gain = rgc_pkg::GainW'($urandom_range(256, 1023));
        2: gain = rgc_pkg::GainW'($urandom_range(0, 65535));
        default: begin
          case ($urandom_range(0, 4))
            0:       gain = 16'd0;
            1:       gain = 16'd255;
            2:       gain = 16'd257;
            3:       gain = 16'd768;
            default: gain = 16'hffff;
          endcase
        end
      endcase
      count = rgc_pkg::CountW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                           : $urandom_range(3, 4));
      configure(gain, count);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PhaseItems; k++) begin
        dim = ($urandom_range(0, 3) == 0);
        send_pixel(rgc_pkg::ColorW'(dim ? $urandom_range(0, 31) : $urandom_range(0, 255)),
                   rgc_pkg::ColorW'(dim ? $urandom_range(0, 31) : $urandom_range(0, 255)),
                   rgc_pkg::ColorW'(dim ? $urandom_range(0, 31) : $urandom_range(0, 255)),
                   rgc_pkg::ColorW'($urandom_range(0, 255)),
                   (k == PhaseItems - 1) || ($urandom_range(0, 15) == 0));
        if (ph == RandomPhases / 2 && k == PhaseItems / 2) begin
          drain();
        end
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rgb_gain_with_hue_clamp verification clean");
    end else begin
      $display("rgb_gain_with_hue_clamp verification failed");
    end
    $finish;
  end

endmodule
